FILE: design/sdf_pkg.sv
// Shared constants, codes and the CRC-16/ARC byte update for the serial packet deframer.
// No dependencies; compiled first.
package sdf_pkg;

	localparam int StoreDepth = 32;

	// result kinds
	localparam logic [2:0] KIND_GOOD     = 3'd0;
	localparam logic [2:0] KIND_CRC_BAD  = 3'd1;
	localparam logic [2:0] KIND_SYNC_ERR = 3'd2;
	localparam logic [2:0] KIND_LEN_REJ  = 3'd3;
	localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

	// configuration register indexes (byte address / 4)
	localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

	localparam logic [7:0]  SYNC_FIRST_RST    = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST   = 8'h55;
	localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd100;

	localparam logic [15:0] CRC_POLY = 16'hA001;

	// reflected CRC-16, one byte in, eight shift steps
	function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: design/sdf_req_if.sv
// Request channel: one received byte or one timer tick per transfer.
// No dependencies.
interface sdf_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

FILE: design/sdf_rsp_if.sv
// Result channel: one deframer result per transfer.
// No dependencies.
interface sdf_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  pkt_addr;
	logic [4:0]  pkt_len;
	logic [7:0]  pkt_type;
	logic [7:0]  data_byte;
	logic [4:0]  byte_index;
	logic        last;
	logic [15:0] good_count;
	logic [15:0] bad_count;
	logic [15:0] sync_err_count;
	logic [15:0] timeout_count;

	modport source (output valid, output kind, output pkt_addr, output pkt_len,
		output pkt_type, output data_byte, output byte_index, output last,
		output good_count, output bad_count, output sync_err_count,
		output timeout_count, input ready);
	modport sink (input valid, input kind, input pkt_addr, input pkt_len,
		input pkt_type, input data_byte, input byte_index, input last,
		input good_count, input bad_count, input sync_err_count,
		input timeout_count, output ready);
endinterface

FILE: design/serial_packet_deframer_crc16.sv
// Serial packet deframer with CRC-16/ARC check, payload kept in a synchronous RAM.
// Depends on sdf_pkg, sdf_req_if, sdf_rsp_if.
//
//  channel  | direction | handshake         | carries
//  ---------+-----------+-------------------+-----------------------------------------
//  req      | in        | valid/ready       | req_type, rx_byte
//  rsp      | out       | valid/ready       | kind, header, data_byte, index, counters
//  apb      | in        | psel/penable      | sync_first, sync_second, timeout_limit
//
// A new byte or tick can be taken each cycle that req.ready is high. At the CRC high
// byte of a frame with N > 0 payload bytes the RAM is read back one entry a cycle while
// rsp is not stalled, one result per entry, req held off meanwhile. The single RAM read port sets that rate.
// arst_n clears all control state and counters; the payload RAM has no reset.
// A stalled rsp holds the output register and, through it, req and the readback.
module serial_packet_deframer_crc16
	import sdf_pkg::*;
#(
	parameter int PAYLOAD_LIMIT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sdf_req_if.sink     req,
	sdf_rsp_if.source   rsp
);

	localparam int LenLimit = (PAYLOAD_LIMIT < StoreDepth) ? PAYLOAD_LIMIT : StoreDepth;
	localparam int AddrW = $clog2(LenLimit);
	localparam logic [7:0] LenLimitB = 8'(LenLimit);

	typedef enum logic [2:0] {
		PH_HUNT, PH_SYNC2, PH_ADDR, PH_LEN, PH_TYPE, PH_DATA, PH_CRCL, PH_CRCH
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  pkt_addr;
		logic [4:0]  pkt_len;
		logic [7:0]  pkt_type;
		logic [7:0]  data_byte;
		logic [4:0]  byte_index;
		logic        last;
		logic [15:0] good_count;
		logic [15:0] bad_count;
		logic [15:0] sync_err_count;
		logic [15:0] timeout_count;
	} result_t;

	// configuration
	logic [7:0]  sync_first_q, sync_second_q;
	logic [15:0] timeout_limit_q;

	// frame state
	phase_t      phase_q, n_phase;
	logic [7:0]  hdr_addr_q, n_addr;
	logic [4:0]  hdr_len_q, n_len;
	logic [7:0]  hdr_type_q, n_type;
	logic [4:0]  fill_q, n_fill, fill_inc;
	logic [15:0] crc_q, n_crc;
	logic [7:0]  crc_lo_q, n_crclo;
	logic [16:0] idle_q, n_idle;
	logic [15:0] good_q, bad_q, serr_q, tout_q;
	logic [15:0] n_good, n_bad, n_serr, n_tout;

	// step outcome
	logic        single, start_emit, wr_en, accept;
	logic [2:0]  single_kind;
	result_t     single_res, emit_res;

	// readback
	logic        emit_q;
	logic [2:0]  frame_kind_q;
	logic [4:0]  issue_idx_q;
	logic        issue, consume;
	logic        rd_pend_s1;
	logic [4:0]  rd_idx_s1;
	logic [7:0]  mem_rd_s1;
	logic [7:0]  payload_mem [LenLimit];

	// output register
	logic        out_valid_q;
	result_t     out_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q    <= SYNC_FIRST_RST;
			sync_second_q   <= SYNC_SECOND_RST;
			timeout_limit_q <= TIMEOUT_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SYNC_FIRST:    sync_first_q    <= pwdata[7:0];
				REG_SYNC_SECOND:   sync_second_q   <= pwdata[7:0];
				REG_TIMEOUT_LIMIT: timeout_limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SYNC_FIRST:    prdata = {24'h0, sync_first_q};
			REG_SYNC_SECOND:   prdata = {24'h0, sync_second_q};
			REG_TIMEOUT_LIMIT: prdata = {16'h0, timeout_limit_q};
			default:           prdata = '0;
		endcase
	end

	// ---------------- per-item step ----------------
	assign req.ready = !emit_q && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign fill_inc  = fill_q + 5'd1;

	always_comb begin
		n_phase     = phase_q;
		n_addr      = hdr_addr_q;
		n_len       = hdr_len_q;
		n_type      = hdr_type_q;
		n_fill      = fill_q;
		n_crc       = crc_q;
		n_crclo     = crc_lo_q;
		n_idle      = idle_q;
		n_good      = good_q;
		n_bad       = bad_q;
		n_serr      = serr_q;
		n_tout      = tout_q;
		single      = 1'b0;
		single_kind = KIND_GOOD;
		start_emit  = 1'b0;
		wr_en       = 1'b0;
		if (req.req_type) begin
			if (phase_q != PH_HUNT) begin
				if (idle_q > {1'b0, timeout_limit_q}) begin
					n_idle      = '0;
					n_tout      = tout_q + 16'd1;
					n_phase     = PH_HUNT;
					single      = 1'b1;
					single_kind = KIND_TIMEOUT;
				end else begin
					n_idle = idle_q + 17'd1;
				end
			end
		end else begin
			n_idle = '0;
			case (phase_q)
				PH_HUNT: begin
					n_addr  = '0;
					n_len   = '0;
					n_type  = '0;
					n_fill  = '0;
					n_crc   = '0;
					n_crclo = '0;
					if (req.rx_byte == sync_first_q) begin
						n_phase = PH_SYNC2;
					end else begin
						n_serr      = serr_q + 16'd1;
						single      = 1'b1;
						single_kind = KIND_SYNC_ERR;
					end
				end
				PH_SYNC2: begin
					if (req.rx_byte == sync_second_q) begin
						n_phase = PH_ADDR;
					end else begin
						n_phase     = PH_HUNT;
						n_serr      = serr_q + 16'd1;
						single      = 1'b1;
						single_kind = KIND_SYNC_ERR;
					end
				end
				PH_ADDR: begin
					n_addr  = req.rx_byte;
					n_crc   = crc_feed(crc_q, req.rx_byte);
					n_phase = PH_LEN;
				end
				PH_LEN: begin
					if (req.rx_byte >= LenLimitB) begin
						n_phase     = PH_HUNT;
						single      = 1'b1;
						single_kind = KIND_LEN_REJ;
					end else begin
						n_len   = req.rx_byte[4:0];
						n_crc   = crc_feed(crc_q, req.rx_byte);
						n_phase = PH_TYPE;
					end
				end
				PH_TYPE: begin
					n_type  = req.rx_byte;
					n_crc   = crc_feed(crc_q, req.rx_byte);
					n_fill  = '0;
					n_phase = (hdr_len_q != 5'd0) ? PH_DATA : PH_CRCL;
				end
				PH_DATA: begin
					wr_en = 1'b1;
					n_crc = crc_feed(crc_q, req.rx_byte);
					if (fill_inc >= hdr_len_q) begin
						n_fill  = '0;
						n_phase = PH_CRCL;
					end else begin
						n_fill = fill_inc;
					end
				end
				PH_CRCL: begin
					n_crclo = req.rx_byte;
					n_phase = PH_CRCH;
				end
				PH_CRCH: begin
					n_phase = PH_HUNT;
					if ({req.rx_byte, crc_lo_q} == crc_q) begin
						n_good      = good_q + 16'd1;
						single_kind = KIND_GOOD;
					end else begin
						n_bad       = bad_q + 16'd1;
						single_kind = KIND_CRC_BAD;
					end
					if (hdr_len_q == 5'd0) begin
						single = 1'b1;
					end else begin
						start_emit = 1'b1;
					end
				end
				default: n_phase = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			hdr_addr_q <= '0;
			hdr_len_q  <= '0;
			hdr_type_q <= '0;
			fill_q     <= '0;
			crc_q      <= '0;
			crc_lo_q   <= '0;
			idle_q     <= '0;
			good_q     <= '0;
			bad_q      <= '0;
			serr_q     <= '0;
			tout_q     <= '0;
		end else if (accept) begin
			phase_q    <= n_phase;
			hdr_addr_q <= n_addr;
			hdr_len_q  <= n_len;
			hdr_type_q <= n_type;
			fill_q     <= n_fill;
			crc_q      <= n_crc;
			crc_lo_q   <= n_crclo;
			idle_q     <= n_idle;
			good_q     <= n_good;
			bad_q      <= n_bad;
			serr_q     <= n_serr;
			tout_q     <= n_tout;
		end
	end

	// ---------------- payload RAM and readback ----------------
	// read issued only when the slot after the RAM is free or being drained
	assign consume = rd_pend_s1 && (!out_valid_q || rsp.ready);
	assign issue   = emit_q && (issue_idx_q < hdr_len_q) && (!rd_pend_s1 || consume);

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			payload_mem[fill_q[AddrW-1:0]] <= req.rx_byte;
		end
		if (issue) begin
			mem_rd_s1 <= payload_mem[issue_idx_q[AddrW-1:0]];
			rd_idx_s1 <= issue_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q       <= 1'b0;
			frame_kind_q <= KIND_GOOD;
			issue_idx_q  <= '0;
			rd_pend_s1   <= 1'b0;
		end else begin
			if (accept && start_emit) begin
				emit_q       <= 1'b1;
				frame_kind_q <= single_kind;
				issue_idx_q  <= '0;
			end else begin
				if (issue) begin
					issue_idx_q <= issue_idx_q + 5'd1;
				end
				if (consume && (rd_idx_s1 == 5'(hdr_len_q - 5'd1))) begin
					emit_q <= 1'b0;
				end
			end
			if (issue) begin
				rd_pend_s1 <= 1'b1;
			end else if (consume) begin
				rd_pend_s1 <= 1'b0;
			end
		end
	end

	// ---------------- result register ----------------
	always_comb begin
		single_res = '{kind: single_kind, pkt_addr: n_addr, pkt_len: n_len,
			pkt_type: n_type, data_byte: 8'h00, byte_index: 5'd0, last: 1'b1,
			good_count: n_good, bad_count: n_bad, sync_err_count: n_serr,
			timeout_count: n_tout};
		emit_res = '{kind: frame_kind_q, pkt_addr: hdr_addr_q, pkt_len: hdr_len_q,
			pkt_type: hdr_type_q, data_byte: mem_rd_s1, byte_index: rd_idx_s1,
			last: (rd_idx_s1 == 5'(hdr_len_q - 5'd1)),
			good_count: good_q, bad_count: bad_q, sync_err_count: serr_q,
			timeout_count: tout_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && single) || consume) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && single) begin
			out_q <= single_res;
		end else if (consume) begin
			out_q <= emit_res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.kind           = out_q.kind;
	assign rsp.pkt_addr       = out_q.pkt_addr;
	assign rsp.pkt_len        = out_q.pkt_len;
	assign rsp.pkt_type       = out_q.pkt_type;
	assign rsp.data_byte      = out_q.data_byte;
	assign rsp.byte_index     = out_q.byte_index;
	assign rsp.last           = out_q.last;
	assign rsp.good_count     = out_q.good_count;
	assign rsp.bad_count      = out_q.bad_count;
	assign rsp.sync_err_count = out_q.sync_err_count;
	assign rsp.timeout_count  = out_q.timeout_count;

`ifndef NO_ASSERTIONS
	// no new request while the payload is being read back
	a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q |-> !req.ready)
		else $error("request accepted during payload readback");

	// a pending RAM read only exists inside a readback run
	a_read_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> emit_q)
		else $error("RAM read pending outside readback");

	// payload write pointer stays inside the announced length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (fill_q < hdr_len_q))
		else $error("fill index beyond header length");

	// result index stays below the packet length, or is zero
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.byte_index < rsp.pkt_len || rsp.byte_index == 5'd0))
		else $error("result index beyond packet length");
`endif

endmodule
